// ===== design/register_machine_execute_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Register machine execute unit: assertion macros
// Shared assertion shorthands for the execute unit checks.
// ----------------------------------------------------------------------------
`ifndef REGISTER_MACHINE_EXECUTE_UNIT_DEFINES_SVH
`define REGISTER_MACHINE_EXECUTE_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define RME_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define RME_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/rme_pkg.sv =====
// ----------------------------------------------------------------------------
// Register machine execute unit package
// Widths, opcodes and error codes shared by the execute unit and its divider.
// ----------------------------------------------------------------------------
package rme_pkg;

    // data path and register file
    localparam int DATA_W     = 32;
    localparam int NUM_REGS   = 8;   // power of two, index is the low bits
    localparam int REG_IDX_W  = $clog2(NUM_REGS);

    // program and data space
    localparam int PC_W       = 9;
    localparam int PLEN_W     = 10;
    localparam int OPND_W     = 10;
    localparam int DATA_BASE  = 512;
    localparam int MEM_WORDS  = 1024;
    localparam int SPTR_W     = 11;
    localparam int SADDR_W    = 10;

    // stream payload widths
    localparam int OPC_W      = 4;
    localparam int ERR_W      = 2;
    localparam int IN_W       = 48;
    localparam int OUT_W      = 88;

    typedef enum logic [OPC_W-1:0] {
        OP_LOAD  = 4'd0,
        OP_STORE = 4'd1,
        OP_CLEAR = 4'd2,
        OP_ADD   = 4'd3,
        OP_SUB   = 4'd4,
        OP_MUL   = 4'd5,
        OP_DIV   = 4'd6,
        OP_INC   = 4'd7,
        OP_DEC   = 4'd8,
        OP_CMP   = 4'd9,
        OP_PRINT = 4'd10,
        OP_READ  = 4'd11,
        OP_HALT  = 4'd12,
        OP_JL    = 4'd13,
        OP_JG    = 4'd14,
        OP_JE    = 4'd15
    } op_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE     = 2'd0,
        ERR_BAD_JUMP = 2'd1,
        ERR_DIV_ZERO = 2'd2,
        ERR_DATA_FULL = 2'd3
    } err_t;

    // divider handshake
    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== design/rme_div.sv =====
// ----------------------------------------------------------------------------
// Register machine unsigned divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rme_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  rme_pkg::div_ctrl_t        ctrl,
    input  logic [rme_pkg::DATA_W-1:0] dividend,
    input  logic [rme_pkg::DATA_W-1:0] divisor,
    output rme_pkg::div_stat_t        stat,
    output logic [rme_pkg::DATA_W-1:0] quotient
);

    localparam int CNT_W = $clog2(rme_pkg::DATA_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(rme_pkg::DATA_W - 1);

    logic                       busy_reg;
    logic                       done_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [rme_pkg::DATA_W-1:0] rem_reg, rem_next;
    logic [rme_pkg::DATA_W-1:0] quo_reg, quo_next;
    logic [rme_pkg::DATA_W-1:0] dvs_reg;
    logic [rme_pkg::DATA_W:0]   trial;
    logic [rme_pkg::DATA_W:0]   diff;

    // one restoring step
    always_comb begin
        trial = {rem_reg, quo_reg[rme_pkg::DATA_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        if (!diff[rme_pkg::DATA_W]) begin
            rem_next = diff[rme_pkg::DATA_W-1:0];
            quo_next = {quo_reg[rme_pkg::DATA_W-2:0], 1'b1};
        end else begin
            rem_next = trial[rme_pkg::DATA_W-1:0];
            quo_next = {quo_reg[rme_pkg::DATA_W-2:0], 1'b0};
        end
    end

    // step control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= !ctrl.start && busy_reg && (cnt_reg == LAST_STEP);
            if (ctrl.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // remainder and quotient shift registers
    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

// ===== design/register_machine_execute_unit.sv =====
// ----------------------------------------------------------------------------
// Register machine execute unit
// Executes one decoded instruction per transaction on a small register file.
// ----------------------------------------------------------------------------
// One instruction is in flight at a time. The register file memory is read at
// the edge that takes a transaction, the instruction executes in the following
// cycle and its result is registered at the next edge, unless completion
// stalls on the output register; the input is ready again in the cycle in
// which the result appears. A divide whose divisor is non-zero runs through the
// restoring divider, one quotient bit a cycle: the execute state starts it, the
// divide state waits through its 32 steps for its done flag, and the finish
// state then registers the result like that of any other instruction.
// The result sits in an output register, so a new transaction is taken while
// an earlier result still waits; completion stalls only while that register
// still holds a result that has not been taken. After halt every instruction
// is ignored and reports the held pc with halted set, until reset.
`include "register_machine_execute_unit_defines.svh"

module register_machine_execute_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration: program_length
    input  logic                            cfg_wr_en,
    input  logic [rme_pkg::PLEN_W-1:0]      cfg_wr_data,
    // instruction stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // opcode[3:0], first_operand[13:4], second_operand[45:14], zero fill
    input  logic [rme_pkg::IN_W-1:0]        s_tdata,
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // next_pc[8:0], print_valid[9], print_value[41:10], store_valid[42],
    // store_address[52:43], store_data[84:53], halted[85], error_code[87:86]
    output logic [rme_pkg::OUT_W-1:0]       m_tdata
);

    localparam int DW  = rme_pkg::DATA_W;
    localparam int RIW = rme_pkg::REG_IDX_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_FIN
    } state_t;

    state_t state_reg;

    // architectural state
    logic [rme_pkg::PC_W-1:0]   pc_reg;
    logic [rme_pkg::SPTR_W-1:0] sptr_reg;
    logic [rme_pkg::PLEN_W-1:0] plen_reg;
    logic                       halt_reg;
    logic                       less_reg, greater_reg, equal_reg;
    logic [rme_pkg::NUM_REGS-1:0] valid_reg;

    // latched instruction
    rme_pkg::op_t               op_reg;
    logic [rme_pkg::OPND_W-1:0] first_reg;
    logic [DW-1:0]              second_reg;

    // register file memory
    logic [DW-1:0] reg_mem [rme_pkg::NUM_REGS];
    logic [DW-1:0] rd_a_reg, rd_b_reg;
    logic          a_valid_reg, b_valid_reg;
    logic [RIW-1:0] rd_idx, rs_idx;
    logic          take;

    // output register
    logic          m_tvalid_reg;
    logic [rme_pkg::OUT_W-1:0] m_tdata_reg;

    // execute results
    logic [DW-1:0] a, b;
    logic [DW-1:0] ma, mb, div_res;
    logic          div_neg;
    logic          out_free, finish, commit, div_go;
    logic          wr_en;
    logic [DW-1:0] wr_data;
    logic [rme_pkg::PC_W-1:0]   res_pc;
    logic          res_pv, res_sv, res_halted;
    logic [DW-1:0] res_pval, res_sdata;
    logic [rme_pkg::SADDR_W-1:0] res_saddr;
    rme_pkg::err_t res_err;
    logic          less_next, greater_next, equal_next, halt_next;
    logic [rme_pkg::SPTR_W-1:0] sptr_next;
    logic          jump_flag;
    logic [DW-1:0] sa, sb;

    rme_pkg::div_ctrl_t div_ctrl;
    rme_pkg::div_stat_t div_stat;
    logic [DW-1:0]      div_q;

    assign s_tready = (state_reg == S_IDLE);
    assign take     = s_tvalid && s_tready;
    assign rd_idx   = s_tdata[rme_pkg::OPC_W +: RIW];
    assign rs_idx   = s_tdata[rme_pkg::OPC_W + rme_pkg::OPND_W +: RIW];

    // register file read on acceptance, write on completion
    always_ff @(posedge aclk) begin
        if (take) begin
            rd_a_reg <= reg_mem[rd_idx];
            rd_b_reg <= reg_mem[rs_idx];
        end
        if (wr_en) begin
            reg_mem[first_reg[RIW-1:0]] <= wr_data;
        end
    end

    // entries never written read as zero
    assign a = a_valid_reg ? rd_a_reg : '0;
    assign b = b_valid_reg ? rd_b_reg : '0;

    // divider operands on magnitudes, sign restored afterwards
    assign ma       = a[DW-1] ? (~a + 1'b1) : a;
    assign mb       = b[DW-1] ? (~b + 1'b1) : b;
    assign div_neg  = a[DW-1] ^ b[DW-1];
    assign div_res  = div_neg ? (~div_q + 1'b1) : div_q;

    assign div_go         = (state_reg == S_EXEC) && !halt_reg
                            && (op_reg == rme_pkg::OP_DIV) && (b != '0);
    assign div_ctrl.start = div_go;

    rme_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (div_ctrl),
        .dividend (ma),
        .divisor  (mb),
        .stat     (div_stat),
        .quotient (div_q)
    );

    assign out_free = !m_tvalid_reg || m_tready;
    assign finish   = ((state_reg == S_EXEC) && !div_go) || (state_reg == S_FIN);
    assign commit   = finish && out_free;

    // instruction execution
    always_comb begin
        wr_en        = 1'b0;
        wr_data      = a;
        res_pc       = pc_reg + 1'b1;
        res_pv       = 1'b0;
        res_pval     = '0;
        res_sv       = 1'b0;
        res_saddr    = '0;
        res_sdata    = '0;
        res_err      = rme_pkg::ERR_NONE;
        less_next    = less_reg;
        greater_next = greater_reg;
        equal_next   = equal_reg;
        halt_next    = halt_reg;
        sptr_next    = sptr_reg;
        jump_flag    = 1'b0;
        sa           = a ^ {1'b1, {(DW-1){1'b0}}};
        sb           = b ^ {1'b1, {(DW-1){1'b0}}};
        if (halt_reg) begin
            res_pc = pc_reg;
        end else begin
            case (op_reg)
                rme_pkg::OP_LOAD: begin
                    wr_en   = 1'b1;
                    wr_data = second_reg;
                end
                rme_pkg::OP_STORE: begin
                    if (sptr_reg >= rme_pkg::SPTR_W'(rme_pkg::MEM_WORDS)) begin
                        res_err = rme_pkg::ERR_DATA_FULL;
                    end else begin
                        res_sv    = 1'b1;
                        res_saddr = sptr_reg[rme_pkg::SADDR_W-1:0];
                        res_sdata = a;
                        sptr_next = sptr_reg + 1'b1;
                    end
                end
                rme_pkg::OP_CLEAR: begin
                    wr_en   = 1'b1;
                    wr_data = '0;
                end
                rme_pkg::OP_ADD: begin
                    wr_en   = 1'b1;
                    wr_data = a + b;
                end
                rme_pkg::OP_SUB: begin
                    wr_en   = 1'b1;
                    wr_data = a - b;
                end
                rme_pkg::OP_MUL: begin
                    wr_en   = 1'b1;
                    wr_data = a * b;
                end
                rme_pkg::OP_DIV: begin
                    if (b == '0) begin
                        res_err = rme_pkg::ERR_DIV_ZERO;
                    end else begin
                        wr_en   = 1'b1;
                        wr_data = div_res;
                    end
                end
                rme_pkg::OP_INC: begin
                    wr_en   = 1'b1;
                    wr_data = a + 1'b1;
                end
                rme_pkg::OP_DEC: begin
                    wr_en   = 1'b1;
                    wr_data = a - 1'b1;
                end
                rme_pkg::OP_CMP: begin
                    less_next    = sa < sb;
                    greater_next = sa > sb;
                    equal_next   = sa == sb;
                end
                rme_pkg::OP_PRINT: begin
                    res_pv   = 1'b1;
                    res_pval = a;
                end
                rme_pkg::OP_READ: begin
                end
                rme_pkg::OP_HALT: begin
                    halt_next = 1'b1;
                end
                rme_pkg::OP_JL: jump_flag = less_reg;
                rme_pkg::OP_JG: jump_flag = greater_reg;
                rme_pkg::OP_JE: jump_flag = equal_reg;
                default: begin
                end
            endcase
            // jump only to a target inside the loaded program
            if (jump_flag) begin
                if ((first_reg < plen_reg) && !first_reg[rme_pkg::OPND_W-1]) begin
                    res_pc = first_reg[rme_pkg::PC_W-1:0];
                end else begin
                    res_err = rme_pkg::ERR_BAD_JUMP;
                end
            end
        end
        res_halted = halt_next;
        wr_en      = wr_en && commit && !halt_reg;
    end

    // sequencer, architectural state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            pc_reg       <= '0;
            sptr_reg     <= rme_pkg::SPTR_W'(rme_pkg::DATA_BASE);
            plen_reg     <= '0;
            halt_reg     <= 1'b0;
            less_reg     <= 1'b0;
            greater_reg  <= 1'b0;
            equal_reg    <= 1'b0;
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                plen_reg <= cfg_wr_data;
            end
            // output valid: set on completion, cleared once taken
            if (commit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (take) begin
                        op_reg      <= rme_pkg::op_t'(s_tdata[rme_pkg::OPC_W-1:0]);
                        first_reg   <= s_tdata[rme_pkg::OPC_W +: rme_pkg::OPND_W];
                        second_reg  <= s_tdata[rme_pkg::OPC_W + rme_pkg::OPND_W +: DW];
                        a_valid_reg <= valid_reg[rd_idx];
                        b_valid_reg <= valid_reg[rs_idx];
                        state_reg   <= S_EXEC;
                    end
                end
                S_EXEC, S_FIN: begin
                    if (div_go) begin
                        state_reg <= S_DIV;
                    end else if (commit) begin
                        pc_reg       <= res_pc;
                        sptr_reg     <= sptr_next;
                        halt_reg     <= halt_next;
                        less_reg     <= less_next;
                        greater_reg  <= greater_next;
                        equal_reg    <= equal_next;
                        if (wr_en) begin
                            valid_reg[first_reg[RIW-1:0]] <= 1'b1;
                        end
                        m_tdata_reg  <= {res_err, res_halted, res_sdata, res_saddr,
                                         res_sv, res_pval, res_pv, res_pc};
                        state_reg    <= S_IDLE;
                    end
                end
                S_DIV: begin
                    if (div_stat.done) begin
                        state_reg <= S_FIN;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // checks
    `RME_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, take, !s_tready,
        "second transaction accepted while an instruction is in flight")
    `RME_ASSERT_NOW(a_div_in_div_state, aclk, aresetn, div_stat.busy, state_reg == S_DIV,
        "divider busy outside the divide state")
    `RME_ASSERT_NOW(a_sptr_bound, aclk, aresetn, 1'b1,
        sptr_reg <= rme_pkg::SPTR_W'(rme_pkg::MEM_WORDS),
        "store pointer past the end of the data area")
    `RME_ASSERT_NOW(a_halt_sticky_result, aclk, aresetn, commit && halt_reg,
        !wr_en && (res_pc == pc_reg) && (res_err == rme_pkg::ERR_NONE),
        "instruction after halt changed state")

endmodule

// ===== tb/rme_result_checker.sv =====
// ----------------------------------------------------------------------------
// Register machine execute unit: result checker
// Follows both stream channels and the program length write port. Each
// accepted instruction is run through a local model of the register file,
// flags, pc, data pointer and halt state. The expected result is queued and
// each result transaction is compared with it field by field.
// ----------------------------------------------------------------------------
module rme_result_checker
    import rme_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [PLEN_W-1:0]   cfg_wr_data,
    input  logic                s_tvalid,
    input  logic                s_tready,
    // opcode, first_operand, second_operand, zero fill
    input  logic [IN_W-1:0]     s_tdata,
    input  logic                m_tvalid,
    input  logic                m_tready,
    // next_pc, print_valid, print_value, store_valid, store_address,
    // store_data, halted, error_code
    input  logic [OUT_W-1:0]    m_tdata,
    output int                  mismatch_count,
    output int                  results_pending
);

    // result layout, most significant field first
    typedef struct packed {
        err_t                   error_code;
        logic                   halted;
        logic [DATA_W-1:0]      store_data;
        logic [SADDR_W-1:0]     store_address;
        logic                   store_valid;
        logic [DATA_W-1:0]      print_value;
        logic                   print_valid;
        logic [PC_W-1:0]        next_pc;
    } exec_result_t;

    // machine state as the model sees it
    logic [DATA_W-1:0]  gpr [NUM_REGS];
    logic               lt_flag;
    logic               gt_flag;
    logic               eq_flag;
    logic [PC_W-1:0]    pc;
    logic [SPTR_W-1:0]  data_ptr;
    logic               stopped;
    logic [PLEN_W-1:0]  prog_len;

    exec_result_t       predicted_results [$];
    int                 fails = 0;

    // execute one instruction on the local state and return its result
    function automatic exec_result_t execute_instr(input logic [IN_W-1:0] instr);
        op_t                op;
        logic [OPND_W-1:0]  first;
        logic [DATA_W-1:0]  second;
        logic [DATA_W-1:0]  a;
        logic [DATA_W-1:0]  b;
        logic [REG_IDX_W-1:0] rd;
        longint             quot;
        logic               take_jump;
        int                 jump_limit;
        exec_result_t       res;

        op        = op_t'(instr[3:0]);
        first     = instr[13:4];
        second    = instr[45:14];
        rd        = first[REG_IDX_W-1:0];
        a         = gpr[rd];
        b         = gpr[second[REG_IDX_W-1:0]];
        take_jump = 1'b0;
        res       = '0;

        // halted machine ignores everything and holds the pc
        if (stopped) begin
            res.next_pc = pc;
            res.halted  = 1'b1;
            return res;
        end

        res.next_pc    = pc + 1'b1;
        res.error_code = ERR_NONE;
        case (op)
            OP_LOAD:  gpr[rd] = second;
            OP_STORE: begin
                if (data_ptr >= MEM_WORDS) begin
                    res.error_code = ERR_DATA_FULL;
                end else begin
                    res.store_valid   = 1'b1;
                    res.store_address = data_ptr[SADDR_W-1:0];
                    res.store_data    = a;
                    data_ptr          = data_ptr + 1'b1;
                end
            end
            OP_CLEAR: gpr[rd] = '0;
            OP_ADD:   gpr[rd] = a + b;
            OP_SUB:   gpr[rd] = a - b;
            OP_MUL:   gpr[rd] = a * b;
            OP_DIV: begin
                // 64-bit quotient keeps the most negative over minus one defined
                if (b == '0) begin
                    res.error_code = ERR_DIV_ZERO;
                end else begin
                    quot    = longint'($signed(a)) / longint'($signed(b));
                    gpr[rd] = quot[DATA_W-1:0];
                end
            end
            OP_INC:   gpr[rd] = a + 1'b1;
            OP_DEC:   gpr[rd] = a - 1'b1;
            OP_CMP: begin
                lt_flag = $signed(a) <  $signed(b);
                gt_flag = $signed(a) >  $signed(b);
                eq_flag = $signed(a) == $signed(b);
            end
            OP_PRINT: begin
                res.print_valid = 1'b1;
                res.print_value = a;
            end
            OP_READ:  ;
            OP_HALT:  stopped = 1'b1;
            OP_JL:    take_jump = lt_flag;
            OP_JG:    take_jump = gt_flag;
            OP_JE:    take_jump = eq_flag;
            default:  ;
        endcase

        // taken jump lands on its target only when it is inside the program
        if (take_jump) begin
            jump_limit = (prog_len < 512) ? int'(prog_len) : 512;
            if (int'(first) < jump_limit)
                res.next_pc = first[PC_W-1:0];
            else
                res.error_code = ERR_BAD_JUMP;
        end

        pc         = res.next_pc;
        res.halted = stopped;
        return res;
    endfunction

    function automatic void compare_field(input string fname,
                                          input logic [DATA_W-1:0] want,
                                          input logic [DATA_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
            fails++;
        end
    endfunction

    // model update and comparison, results before instructions in one cycle
    always @(posedge aclk) begin
        exec_result_t want;
        exec_result_t got;

        if (!aresetn) begin
            foreach (gpr[i])
                gpr[i] = '0;
            lt_flag  = 1'b0;
            gt_flag  = 1'b0;
            eq_flag  = 1'b0;
            pc       = '0;
            data_ptr = SPTR_W'(DATA_BASE);
            stopped  = 1'b0;
            prog_len = '0;
            predicted_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = exec_result_t'(m_tdata);
                if (predicted_results.size() == 0) begin
                    $display("%0t: result with none expected, expected none, actual %h",
                             $time, m_tdata);
                    fails++;
                end else begin
                    want = predicted_results.pop_front();
                    compare_field("next_pc", DATA_W'(want.next_pc),
                                  DATA_W'(got.next_pc));
                    compare_field("print_valid", DATA_W'(want.print_valid),
                                  DATA_W'(got.print_valid));
                    compare_field("print_value", want.print_value, got.print_value);
                    compare_field("store_valid", DATA_W'(want.store_valid),
                                  DATA_W'(got.store_valid));
                    compare_field("store_address", DATA_W'(want.store_address),
                                  DATA_W'(got.store_address));
                    compare_field("store_data", want.store_data, got.store_data);
                    compare_field("halted", DATA_W'(want.halted),
                                  DATA_W'(got.halted));
                    compare_field("error_code", DATA_W'(want.error_code),
                                  DATA_W'(got.error_code));
                end
            end
            if (s_tvalid && s_tready)
                predicted_results.push_back(execute_instr(s_tdata));
            if (cfg_wr_en)
                prog_len = cfg_wr_data;
        end
        mismatch_count  <= fails;
        results_pending <= predicted_results.size();
    end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Register machine execute unit testbench
// Drives decoded instructions into the execute unit: a directed pass over the
// arithmetic corner cases, jumps and stores, then store-heavy random
// instruction streams under three idling patterns and several program
// lengths, more stores until the data area fills and overflows, and finally
// halt with ignored instructions after.
// ----------------------------------------------------------------------------
module testbench;
    import rme_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 40;

    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic [PLEN_W-1:0]   cfg_wr_data = '0;
    logic                s_tvalid    = 1'b0;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata     = '0;
    logic                m_tvalid;
    logic                m_tready    = 1'b0;
    logic [OUT_W-1:0]    m_tdata;

    int                  mismatch_count;
    int                  results_pending;
    int                  send_idle_pct = 0;
    int                  recv_idle_pct = 0;
    int                  stores_sent   = 0;
    int                  stall_cycles  = 0;
    logic [PLEN_W-1:0]   cur_length    = '0;

    always #1 aclk = ~aclk;

    register_machine_execute_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    rme_result_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    // result side back-pressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // present one instruction, with random gaps in front of it
    task automatic send_instr(input op_t op, input logic [OPND_W-1:0] first,
                              input logic [DATA_W-1:0] second);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, second, first, op};
        do
            @(posedge aclk);
        while (!s_tready);
        if (op == OP_STORE)
            stores_sent++;
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_pending != 0)
            @(posedge aclk);
    endtask

    // program length only changes with the unit idle
    task automatic write_length(input logic [PLEN_W-1:0] len);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        cur_length  = len;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // random instruction, jumps mostly aimed up to just past the program end and often after cmp
    task automatic random_instr(input int store_pct);
        op_t               op;
        logic [OPND_W-1:0] first;
        logic [DATA_W-1:0] second;
        int                lim;

        if ($urandom_range(99) < store_pct) begin
            op = OP_STORE;
        end else begin
            op = op_t'(OPC_W'($urandom_range(15)));
            if (op == OP_HALT)
                op = OP_CMP;
        end
        first  = OPND_W'($urandom_range(1023));
        second = $urandom();
        if (op == OP_LOAD) begin
            case ($urandom_range(5))
                0: second = 32'h8000_0000;
                1: second = 32'h7fff_ffff;
                2: second = 32'hffff_ffff;
                3: second = DATA_W'($urandom_range(15));
                default: ;
            endcase
        end
        if (op inside {OP_JL, OP_JG, OP_JE}) begin
            lim = (cur_length > 1020) ? 1023 : int'(cur_length) + 3;
            if ($urandom_range(3) != 0)
                first = OPND_W'($urandom_range(lim));
            if ($urandom_range(1) != 0)
                send_instr(OP_CMP, OPND_W'($urandom_range(1023)), $urandom());
        end
        send_instr(op, first, second);
    endtask

    // stimulus and verdict
    initial begin
        int ph;
        int n;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // arithmetic corners, program length still zero from reset
        send_instr(OP_LOAD,  10'd0,   32'h8000_0000);
        send_instr(OP_LOAD,  10'h3f9, 32'hffff_ffff);
        send_instr(OP_LOAD,  10'd2,   32'h7fff_ffff);
        send_instr(OP_LOAD,  10'd3,   32'd7);
        send_instr(OP_LOAD,  10'd4,   32'hffff_ffec);
        send_instr(OP_DIV,   10'd0,   32'd1);           // most negative over -1
        send_instr(OP_DIV,   10'd4,   32'd3);           // -20 / 7 truncates
        send_instr(OP_DIV,   10'd2,   32'd5);           // divide by zero
        send_instr(OP_ADD,   10'd2,   32'd1);
        send_instr(OP_INC,   10'd2,   32'd0);
        send_instr(OP_INC,   10'd2,   32'hffff_fff8);   // wraps past the top
        send_instr(OP_SUB,   10'd6,   32'd2);
        send_instr(OP_MUL,   10'd3,   32'd1);
        send_instr(OP_DEC,   10'd5,   32'd0);
        send_instr(OP_CLEAR, 10'd3,   32'd0);
        send_instr(OP_CMP,   10'd0,   32'd1);           // less
        send_instr(OP_JL,    10'd0,   32'd0);           // target beyond empty program
        send_instr(OP_JG,    10'd5,   32'd0);           // flag clear
        send_instr(OP_PRINT, 10'd4,   32'hffff_ffff);
        send_instr(OP_READ,  10'h3ff, 32'hffff_ffff);
        send_instr(OP_STORE, 10'h3ff, 32'd0);
        send_instr(OP_STORE, 10'd4,   32'd0);

        // jumps against a full program space
        write_length(10'd512);
        send_instr(OP_CMP,   10'd1,   32'd1);
        send_instr(OP_JE,    10'd511, 32'd0);
        send_instr(OP_CMP,   10'd4,   32'd3);
        send_instr(OP_JL,    10'd0,   32'd0);
        send_instr(OP_CMP,   10'd3,   32'd4);
        send_instr(OP_JG,    10'd512, 32'd0);

        // length above the pc range behaves as 512
        write_length(10'd1023);
        send_instr(OP_CMP,   10'd1,   32'd1);
        send_instr(OP_JE,    10'd511, 32'd0);
        send_instr(OP_JE,    10'd600, 32'd0);

        // random streams under three idling patterns
        for (ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    write_length(PLEN_W'($urandom_range(1, 40)));
                    send_idle_pct = 14;
                    recv_idle_pct <= 49;
                end
                1: begin
                    write_length(PLEN_W'($urandom_range(400, 512)));
                    send_idle_pct = 49;
                    recv_idle_pct <= 14;
                end
                default: begin
                    write_length(PLEN_W'($urandom_range(1023)));
                    send_idle_pct = 0;
                    recv_idle_pct <= 0;
                end
            endcase
            for (n = 0; n < 130; n++)
                random_instr(90);
        end

        // stores until the data area is full and overflows twice
        write_length(10'd300);
        while (stores_sent < 514)
            random_instr(95);

        // halt, then instructions that must be ignored
        send_instr(OP_HALT, OPND_W'($urandom_range(1023)), $urandom());
        for (n = 0; n < 8; n++)
            random_instr(20);

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && results_pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
